// ----- src/aqis_pkg.sv -----
// ----------------------------------------------------------------------------
// aqis_pkg
// Types, breakpoint tables and helpers for the air quality index scorer.
// ----------------------------------------------------------------------------
package aqis_pkg;

    localparam int DUST_W      = 10;
    localparam int GAS_W       = 14;
    localparam int SCORE_W     = 9;
    localparam int SEG_N       = 6;
    localparam int SEG_W       = 3;
    localparam int DIFF_W      = 13;  // widest in-segment offset (CO2 top segment)
    localparam int SPAN_W      = 8;   // widest output span is 199
    localparam int PROD_W      = 20;  // offset * output span < 2^20
    localparam int QUOT_W      = 8;   // quotient stays below the output span
    localparam int RECIP_SHIFT = 33;  // PROD_W + ceil(log2(widest input span))
    localparam int RECIP_W     = 30;  // ceil(2^33 / 9) fits
    localparam int FULL_W      = PROD_W + RECIP_W;

    localparam longint RECIP_ONE = 64'd1 << RECIP_SHIFT;

    typedef logic [DUST_W-1:0]  dust_t;
    typedef logic [GAS_W-1:0]   gas_t;
    typedef logic [SCORE_W-1:0] score_t;
    typedef logic [SEG_W-1:0]   seg_t;

    typedef logic [GAS_W-1:0]   bound_arr_t [SEG_N];
    typedef logic [SCORE_W-1:0] score_arr_t [SEG_N];
    typedef logic [SPAN_W-1:0]  span_arr_t  [SEG_N];
    typedef logic [RECIP_W-1:0] recip_arr_t [SEG_N];

    // Breakpoints: low and high reading of each segment, low and high score.
    localparam bound_arr_t DUST_LO = '{14'd0,   14'd10,  14'd36,  14'd56,  14'd126, 14'd226};
    localparam bound_arr_t DUST_HI = '{14'd9,   14'd35,  14'd55,  14'd125, 14'd225, 14'd325};
    localparam bound_arr_t GAS_LO  = '{14'd400, 14'd801, 14'd1001, 14'd1501, 14'd2001,
                                       14'd5001};
    localparam bound_arr_t GAS_HI  = '{14'd800, 14'd1000, 14'd1500, 14'd2000, 14'd5000,
                                       14'd10000};
    localparam score_arr_t OUT_LO  = '{9'd0,  9'd51,  9'd101, 9'd151, 9'd201, 9'd301};
    localparam score_arr_t OUT_HI  = '{9'd50, 9'd100, 9'd150, 9'd200, 9'd300, 9'd500};

    // Output span per segment (same for both pollutants).
    localparam span_arr_t OUT_SPAN = '{
        SPAN_W'(OUT_HI[0] - OUT_LO[0]), SPAN_W'(OUT_HI[1] - OUT_LO[1]),
        SPAN_W'(OUT_HI[2] - OUT_LO[2]), SPAN_W'(OUT_HI[3] - OUT_LO[3]),
        SPAN_W'(OUT_HI[4] - OUT_LO[4]), SPAN_W'(OUT_HI[5] - OUT_LO[5])
    };

    localparam bound_arr_t DUST_IN_SPAN = '{
        GAS_W'(DUST_HI[0] - DUST_LO[0]), GAS_W'(DUST_HI[1] - DUST_LO[1]),
        GAS_W'(DUST_HI[2] - DUST_LO[2]), GAS_W'(DUST_HI[3] - DUST_LO[3]),
        GAS_W'(DUST_HI[4] - DUST_LO[4]), GAS_W'(DUST_HI[5] - DUST_LO[5])
    };
    localparam bound_arr_t GAS_IN_SPAN = '{
        GAS_W'(GAS_HI[0] - GAS_LO[0]), GAS_W'(GAS_HI[1] - GAS_LO[1]),
        GAS_W'(GAS_HI[2] - GAS_LO[2]), GAS_W'(GAS_HI[3] - GAS_LO[3]),
        GAS_W'(GAS_HI[4] - GAS_LO[4]), GAS_W'(GAS_HI[5] - GAS_LO[5])
    };

    // Rounded-up reciprocals: (p * R) >> 33 equals p / span for all p < 2^20.
    localparam recip_arr_t DUST_RECIP = '{
        RECIP_W'((RECIP_ONE + DUST_IN_SPAN[0] - 1) / DUST_IN_SPAN[0]),
        RECIP_W'((RECIP_ONE + DUST_IN_SPAN[1] - 1) / DUST_IN_SPAN[1]),
        RECIP_W'((RECIP_ONE + DUST_IN_SPAN[2] - 1) / DUST_IN_SPAN[2]),
        RECIP_W'((RECIP_ONE + DUST_IN_SPAN[3] - 1) / DUST_IN_SPAN[3]),
        RECIP_W'((RECIP_ONE + DUST_IN_SPAN[4] - 1) / DUST_IN_SPAN[4]),
        RECIP_W'((RECIP_ONE + DUST_IN_SPAN[5] - 1) / DUST_IN_SPAN[5])
    };
    localparam recip_arr_t GAS_RECIP = '{
        RECIP_W'((RECIP_ONE + GAS_IN_SPAN[0] - 1) / GAS_IN_SPAN[0]),
        RECIP_W'((RECIP_ONE + GAS_IN_SPAN[1] - 1) / GAS_IN_SPAN[1]),
        RECIP_W'((RECIP_ONE + GAS_IN_SPAN[2] - 1) / GAS_IN_SPAN[2]),
        RECIP_W'((RECIP_ONE + GAS_IN_SPAN[3] - 1) / GAS_IN_SPAN[3]),
        RECIP_W'((RECIP_ONE + GAS_IN_SPAN[4] - 1) / GAS_IN_SPAN[4]),
        RECIP_W'((RECIP_ONE + GAS_IN_SPAN[5] - 1) / GAS_IN_SPAN[5])
    };

    // Segment pick and clamp for one reading.
    typedef struct packed {
        logic              fixed;  // clamped to a segment end, no interpolation
        score_t            base;
        seg_t              seg;
        logic [DIFF_W-1:0] diff;
    } front_t;

    // After the span multiply.
    typedef struct packed {
        logic              fixed;
        score_t            base;
        seg_t              seg;
        logic [PROD_W-1:0] prod;
    } mid_t;

    function automatic front_t seg_front(gas_t v, bound_arr_t lo, bound_arr_t hi);
        front_t f;
        seg_t   s;
        gas_t   d_full;
        s = '0;
        // Tops are monotonic: segment = number of tops below the reading.
        for (int i = 0; i < SEG_N - 1; i++) begin
            s = s + SEG_W'(v > hi[i]);
        end
        d_full = v - lo[s];
        f.seg  = s;
        f.diff = d_full[DIFF_W-1:0];
        if (v <= lo[s]) begin
            f.fixed = 1'b1;
            f.base  = OUT_LO[s];
        end else if (v >= hi[s]) begin
            f.fixed = 1'b1;
            f.base  = OUT_HI[s];
        end else begin
            f.fixed = 1'b0;
            f.base  = OUT_LO[s];
        end
        return f;
    endfunction

    function automatic mid_t span_mult(front_t f);
        mid_t m;
        m.fixed = f.fixed;
        m.base  = f.base;
        m.seg   = f.seg;
        m.prod  = PROD_W'(f.diff * OUT_SPAN[f.seg]);
        return m;
    endfunction

    function automatic score_t finish(mid_t m, logic [RECIP_W-1:0] recip);
        logic [FULL_W-1:0] full;
        logic [QUOT_W-1:0] quot;
        full = FULL_W'(m.prod) * FULL_W'(recip);
        quot = full[RECIP_SHIFT +: QUOT_W];
        return m.fixed ? m.base : SCORE_W'(m.base + SCORE_W'(quot));
    endfunction

endpackage

// ----- src/aqis_in_if.sv -----
// ----------------------------------------------------------------------------
// aqis_in_if
// Reading channel: one PM2.5 and one CO2 reading per item.
// ----------------------------------------------------------------------------
interface aqis_in_if;
    logic            valid;
    logic            ready;
    aqis_pkg::dust_t dust_reading;
    aqis_pkg::gas_t  gas_reading;

    modport source (output valid, output dust_reading, output gas_reading, input ready);
    modport sink   (input valid, input dust_reading, input gas_reading, output ready);
endinterface

// ----- src/aqis_out_if.sv -----
// ----------------------------------------------------------------------------
// aqis_out_if
// Score channel: both sub-indices, overall score and dominance flag.
// ----------------------------------------------------------------------------
interface aqis_out_if;
    logic             valid;
    logic             ready;
    aqis_pkg::score_t dust_score;
    aqis_pkg::score_t gas_score;
    aqis_pkg::score_t overall_score;
    logic             gas_dominates;

    modport source (output valid, output dust_score, output gas_score,
                    output overall_score, output gas_dominates, input ready);
    modport sink   (input valid, input dust_score, input gas_score,
                    input overall_score, input gas_dominates, output ready);
endinterface

// ----- src/air_quality_index_scorer_core.sv -----
// ----------------------------------------------------------------------------
// air_quality_index_scorer_core
// Maps PM2.5 and CO2 readings to piecewise linear sub-indices (0..500)
// and reports the larger one plus a CO2-dominates flag.
//
//   channel   | dir | payload                                          | handshake
//   ----------+-----+--------------------------------------------------+-----------
//   sample    | in  | dust_reading[9:0], gas_reading[13:0]             | valid/ready
//   result    | out | dust_score, gas_score, overall_score [8:0] each, | valid/ready
//             |     | gas_dominates                                    |
//
// One item per cycle sustained while the result side is ready.
// The three stages are: input register, span multiply register, result register
// (reciprocal multiply, add, max). Each stage loads whenever it is empty or the
// stage after it moves, so bubbles are squeezed out under a stalled output.
// Reset clears the stage valid flags only; no item is lost or repeated across stalls.
// ----------------------------------------------------------------------------
module air_quality_index_scorer_core (
    input  logic       clk,
    input  logic       rst_n,
    aqis_in_if.sink    sample,
    aqis_out_if.source result
);
    import aqis_pkg::*;

    // Stage 1: captured readings
    logic   s1_valid_reg;
    dust_t  s1_dust_reg;
    gas_t   s1_gas_reg;

    // Stage 2: segment, clamp info and offset * output span
    logic   s2_valid_reg;
    mid_t   s2_dust_reg;
    mid_t   s2_gas_reg;
    mid_t   s2_dust_next;
    mid_t   s2_gas_next;

    // Stage 3: output register
    logic   out_valid_reg;
    score_t dust_score_reg;
    score_t gas_score_reg;
    score_t overall_reg;
    logic   gas_dom_reg;
    score_t dust_score_next;
    score_t gas_score_next;

    logic   adv_out;
    logic   adv_s2;
    logic   adv_s1;

    // Pipeline advance: a stage loads when empty or when its content moves on.
    assign adv_out      = !out_valid_reg || result.ready;
    assign adv_s2       = !s2_valid_reg  || adv_out;
    assign adv_s1       = !s1_valid_reg  || adv_s2;
    assign sample.ready = adv_s1;

    // Segment pick, clamp and span multiply. Dust uses the same wide compare path.
    assign s2_dust_next = span_mult(seg_front(GAS_W'(s1_dust_reg), DUST_LO, DUST_HI));
    assign s2_gas_next  = span_mult(seg_front(s1_gas_reg, GAS_LO, GAS_HI));

    // Divide by the input span via reciprocal multiply, then add the low score.
    assign dust_score_next = finish(s2_dust_reg, DUST_RECIP[s2_dust_reg.seg]);
    assign gas_score_next  = finish(s2_gas_reg, GAS_RECIP[s2_gas_reg.seg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (adv_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_s1)
        begin
            s1_dust_reg <= sample.dust_reading;
            s1_gas_reg  <= sample.gas_reading;
        end
        if (adv_s2)
        begin
            s2_dust_reg <= s2_dust_next;
            s2_gas_reg  <= s2_gas_next;
        end
        if (adv_out)
        begin
            dust_score_reg <= dust_score_next;
            gas_score_reg  <= gas_score_next;
            // Ties go to dust.
            gas_dom_reg    <= gas_score_next > dust_score_next;
            overall_reg    <= (gas_score_next > dust_score_next) ? gas_score_next
                                                                 : dust_score_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.dust_score    = dust_score_reg;
    assign result.gas_score     = gas_score_reg;
    assign result.overall_score = overall_reg;
    assign result.gas_dominates = gas_dom_reg;

endmodule

// ----- src/aqis_checker.sv -----
// ----------------------------------------------------------------------------
// aqis_checker
// Port-level checks on the score channel of the scorer core.
// ----------------------------------------------------------------------------
module aqis_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input aqis_pkg::score_t dust_score,
    input aqis_pkg::score_t gas_score,
    input aqis_pkg::score_t overall_score,
    input logic             gas_dominates
);
    import aqis_pkg::*;

    localparam score_t SCORE_MAX = OUT_HI[SEG_N-1];

    // A stalled item holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dust_score) && $stable(gas_score)
            && $stable(overall_score) && $stable(gas_dominates))
    else $error("stalled result changed");

    // Overall score is the larger sub-index.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> overall_score == ((gas_score > dust_score) ? gas_score : dust_score))
    else $error("overall score is not the maximum");

    // Flag only when CO2 strictly dominates.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gas_dominates == (gas_score > dust_score))
    else $error("dominance flag wrong");

    // Sub-indices stay within scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dust_score <= SCORE_MAX && gas_score <= SCORE_MAX)
    else $error("sub-index above scale");

endmodule

bind air_quality_index_scorer_core aqis_checker u_aqis_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .dust_score    (result.dust_score),
    .gas_score     (result.gas_score),
    .overall_score (result.overall_score),
    .gas_dominates (result.gas_dominates)
);

// ----- tb/tb_air_quality_index_scorer_core.sv -----
// ----------------------------------------------------------------------------
// tb_air_quality_index_scorer_core
// Self-checking bench for the air quality index scorer. A short table of
// readings covers every breakpoint, both saturation ends, low CO2 and ties.
// Random reading pairs follow, biased toward segment ends. Both handshakes
// idle at random. Every accepted item without a hand-typed result is scored
// by an independent integer model, and each result is checked in order.
// ----------------------------------------------------------------------------
module tb_air_quality_index_scorer_core;

    timeunit 1ns;
    timeprecision 1ps;

    import aqis_pkg::*;

    localparam int NUM_DIRECTED  = 24;
    localparam int NUM_RANDOM    = 1150;
    localparam int MAX_GAP       = 11;
    localparam int TAIL_CYCLES   = 8;     // pipeline is 3 deep, leave some slack
    localparam int QUIET_LIMIT   = 2000;  // cycles with no item moving on either side

    // One scored item as it leaves the block.
    typedef struct packed {
        score_t dust;
        score_t gas;
        score_t overall;
        logic   gas_wins;
    } score_set_t;

    // One row of the directed table. Rows with known set carry a hand-typed
    // result; the rest are scored by the model.
    typedef struct packed {
        dust_t      dust;
        gas_t       gas;
        logic       known;
        score_set_t want;
    } reading_row_t;

    logic clk;
    logic rst_n;

    aqis_in_if  sample_ch ();
    aqis_out_if result_ch ();

    air_quality_index_scorer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    // Results owed by the block, oldest first.
    score_set_t   pending_scores [$];
    int           mismatches;
    int           quiet_cycles;
    bit           sender_burst;
    bit           receiver_burst;
    reading_row_t directed_rows [NUM_DIRECTED];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Scoring model
    // ------------------------------------------------------------------------

    // Truncating interpolation inside one segment, clamped at both ends.
    function automatic int ramp(int v, int in_lo, int in_hi, int out_lo, int out_hi);
        if (v <= in_lo)
            return out_lo;
        if (v >= in_hi)
            return out_hi;
        return out_lo + ((v - in_lo) * (out_hi - out_lo)) / (in_hi - in_lo);
    endfunction

    // First segment whose top covers the reading; the last one is open ended.
    function automatic score_t dust_index(dust_t reading);
        int v;
        int r;
        v = int'(reading);
        if (v <= 9)
            r = ramp(v, 0, 9, 0, 50);
        else if (v <= 35)
            r = ramp(v, 10, 35, 51, 100);
        else if (v <= 55)
            r = ramp(v, 36, 55, 101, 150);
        else if (v <= 125)
            r = ramp(v, 56, 125, 151, 200);
        else if (v <= 225)
            r = ramp(v, 126, 225, 201, 300);
        else
            r = ramp(v, 226, 325, 301, 500);
        return score_t'(r);
    endfunction

    function automatic score_t gas_index(gas_t reading);
        int v;
        int r;
        v = int'(reading);
        if (v <= 800)
            r = ramp(v, 400, 800, 0, 50);
        else if (v <= 1000)
            r = ramp(v, 801, 1000, 51, 100);
        else if (v <= 1500)
            r = ramp(v, 1001, 1500, 101, 150);
        else if (v <= 2000)
            r = ramp(v, 1501, 2000, 151, 200);
        else if (v <= 5000)
            r = ramp(v, 2001, 5000, 201, 300);
        else
            r = ramp(v, 5001, 10000, 301, 500);
        return score_t'(r);
    endfunction

    // Overall score is the larger sub-index; a tie goes to dust.
    function automatic score_set_t predict_scores(dust_t dust, gas_t gas);
        score_set_t s;
        s.dust     = dust_index(dust);
        s.gas      = gas_index(gas);
        s.gas_wins = (s.gas > s.dust);
        s.overall  = s.gas_wins ? s.gas : s.dust;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic reading_row_t entry(int d, int g, bit known,
                                           int ds = 0, int gs = 0, int os = 0,
                                           bit gw = 1'b0);
        reading_row_t r;
        r.dust          = dust_t'(d);
        r.gas           = gas_t'(g);
        r.known         = known;
        r.want.dust     = score_t'(ds);
        r.want.gas      = score_t'(gs);
        r.want.overall  = score_t'(os);
        r.want.gas_wins = gw;
        return r;
    endfunction

    // Mostly readings that land inside the table, some near a segment end,
    // some anywhere in the field.
    function automatic dust_t pick_dust();
        int v;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            v = $urandom_range(0, 1023);
        end else if (sel < 7) begin
            v = $urandom_range(0, 340);
        end else begin
            case ($urandom_range(0, 12))
                0:       v = 0;
                1:       v = 9;
                2:       v = 10;
                3:       v = 35;
                4:       v = 36;
                5:       v = 55;
                6:       v = 56;
                7:       v = 125;
                8:       v = 126;
                9:       v = 225;
                10:      v = 226;
                11:      v = 325;
                default: v = 1023;
            endcase
            v = v + $urandom_range(0, 4) - 2;
            if (v < 0)
                v = 0;
            if (v > 1023)
                v = 1023;
        end
        return dust_t'(v);
    endfunction

    function automatic gas_t pick_gas();
        int v;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            v = $urandom_range(0, 16383);
        end else if (sel < 7) begin
            v = $urandom_range(0, 10100);
        end else begin
            case ($urandom_range(0, 15))
                0:       v = 0;
                1:       v = 399;
                2:       v = 400;
                3:       v = 800;
                4:       v = 801;
                5:       v = 1000;
                6:       v = 1001;
                7:       v = 1500;
                8:       v = 1501;
                9:       v = 2000;
                10:      v = 2001;
                11:      v = 5000;
                12:      v = 5001;
                13:      v = 9999;
                14:      v = 10000;
                default: v = 16383;
            endcase
            v = v + $urandom_range(0, 4) - 2;
            if (v < 0)
                v = 0;
            if (v > 16383)
                v = 16383;
        end
        return gas_t'(v);
    endfunction

    // Offer one reading pair and hold it until the block takes it. Called
    // in the step of the previous accept, so valid gets one update per step.
    task automatic send_reading(dust_t dust, gas_t gas, bit known, score_set_t want);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.dust_reading <= dust;
        sample_ch.gas_reading  <= gas;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        // Accepted at this edge; the result is owed from now on.
        pending_scores.push_back(known ? want : predict_scores(dust, gas));
    endtask

    // Stop offering and wait until the block has delivered everything owed.
    // Always waits on the clock before returning, so the next send starts a new step.
    task automatic drain_scores();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_scores.size() != 0);
    endtask

    task automatic check_field(string field, logic [SCORE_W-1:0] want,
                               logic [SCORE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        score_set_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_scores.size() == 0)
            begin
                $display("%0t: unexpected result, expected nothing, got %0d/%0d/%0d/%0d",
                         $time, result_ch.dust_score, result_ch.gas_score,
                         result_ch.overall_score, result_ch.gas_dominates);
                mismatches++;
            end
            else
            begin
                want = pending_scores.pop_front();
                check_field("dust_score", want.dust, result_ch.dust_score);
                check_field("gas_score", want.gas, result_ch.gas_score);
                check_field("overall_score", want.overall, result_ch.overall_score);
                check_field("gas_dominates", SCORE_W'(want.gas_wins),
                            SCORE_W'(result_ch.gas_dominates));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a long run of cycles with no item moving means a hang
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready)
                   || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("air_quality_index_scorer_core regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: ready drops for a random number of cycles before each
    // result, with occasional stretches of always-ready.
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        int taken;
        result_ch.ready <= 1'b0;
        receiver_burst = 1'b0;
        taken = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 40 == 0)
                receiver_burst = ($urandom_range(0, 3) == 0);
            gap = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random readings, drain, verdict
    // ------------------------------------------------------------------------
    initial
    begin
        score_set_t no_want;
        mismatches   = 0;
        quiet_cycles = 0;
        sender_burst = 1'b0;
        no_want      = '0;

        sample_ch.valid        <= 1'b0;
        sample_ch.dust_reading <= '0;
        sample_ch.gas_reading  <= '0;
        rst_n                  <= 1'b0;

        // Breakpoint table walk. Segment ends and saturation have scores that
        // are plain from the tables; interior points go through the model.
        directed_rows = '{
            entry(0,    0,     1, 0,   0,   0,   0),  // both at the bottom
            entry(1023, 16383, 1, 500, 500, 500, 0),  // both fields at maximum
            entry(325,  10000, 1, 500, 500, 500, 0),  // top of last segment
            entry(326,  10001, 1, 500, 500, 500, 0),  // just past, saturated
            entry(0,    399,   1, 0,   0,   0,   0),  // CO2 below 400 ppm
            entry(0,    400,   1, 0,   0,   0,   0),  // CO2 at 400 ppm
            entry(9,    800,   1, 50,  50,  50,  0),  // tie, dust keeps the flag
            entry(10,   801,   1, 51,  51,  51,  0),
            entry(35,   1000,  1, 100, 100, 100, 0),
            entry(36,   1001,  1, 101, 101, 101, 0),
            entry(55,   1500,  1, 150, 150, 150, 0),
            entry(56,   1501,  1, 151, 151, 151, 0),
            entry(125,  2000,  1, 200, 200, 200, 0),
            entry(126,  2001,  1, 201, 201, 201, 0),
            entry(225,  5000,  1, 300, 300, 300, 0),
            entry(226,  5001,  1, 301, 301, 301, 0),
            entry(0,    16383, 1, 0,   500, 500, 1),  // CO2 alone saturated
            entry(1023, 0,     1, 500, 0,   500, 0),  // dust alone saturated
            entry(324,  9999,  0),                    // one below both tops
            entry(5,    600,   0),                    // first segment interiors
            entry(20,   1700,  0),                    // CO2 wins inside segments
            entry(341,  5461,  0),                    // alternating bit patterns
            entry(682,  10922, 0),
            entry(100,  3000,  0)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_reading(directed_rows[i].dust, directed_rows[i].gas,
                         directed_rows[i].known, directed_rows[i].want);

        // Let the pipeline run dry before the random part.
        drain_scores();

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            // Re-roll the sender idle style now and then so back-to-back
            // stretches and gappy stretches both happen.
            if (i % 64 == 0)
                sender_burst = ($urandom_range(0, 3) == 0);
            // Hold off mid-run until every owed result is back.
            if (i == NUM_RANDOM / 2)
                drain_scores();
            send_reading(pick_dust(), pick_gas(), 1'b0, no_want);
        end

        drain_scores();
        // A few more cycles to catch any stray result.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_scores.size() == 0)
        begin
            $display("air_quality_index_scorer_core regression: pass");
        end
        else
        begin
            $display("air_quality_index_scorer_core regression: fail");
        end
        $finish;
    end

endmodule
